/* sv/overwriting_item_ring_buffer_defines.svh */
// Assertion macros for the ring buffer RTL.
// Included by overwriting_item_ring_buffer, which carries concurrent assertions; needs a clock and reset in scope.
`ifndef OVERWRITING_ITEM_RING_BUFFER_DEFINES_SVH
`define OVERWRITING_ITEM_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OIRB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define OIRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/oirb_pkg.sv */
// Types, constants and codes for the overwriting item ring buffer.
// Used by oirb_geom and overwriting_item_ring_buffer; depends on nothing.
package oirb_pkg;

   localparam int unsigned MEM_BYTES      = 4096;
   localparam int unsigned MAX_ITEM_BYTES = 64;
   localparam int unsigned SLOT_LIMIT     = 4096;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned IBYTES_W   = 7;
   localparam int unsigned SLOTS_W    = 13;
   localparam int unsigned COUNT_W    = 13;
   localparam int unsigned ADDR_W     = $clog2(MEM_BYTES);
   localparam int unsigned SLOT_IDX_W = $clog2(SLOT_LIMIT);
   localparam int unsigned BIS_W      = (MAX_ITEM_BYTES > 1) ? $clog2(MAX_ITEM_BYTES) : 1;

   localparam int unsigned DIV_W      = $clog2(MEM_BYTES + 1);
   localparam int unsigned DIV_STEP_W = $clog2(DIV_W);
   localparam int unsigned CMP_W      = (DIV_W > SLOTS_W) ? DIV_W : SLOTS_W;
   localparam logic [DIV_W-1:0] MEM_BYTES_VEC = DIV_W'(MEM_BYTES);

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 13;

   localparam logic [IBYTES_W-1:0] ITEM_BYTES_RESET = IBYTES_W'(4);
   localparam logic [SLOTS_W-1:0]  ITEM_SLOTS_RESET = SLOTS_W'(1024);

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ITEM_BYTES = CSR_INDEX_W'(0),
      CSR_ITEM_SLOTS = CSR_INDEX_W'(1)
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_BURST
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  data_byte;
      logic               chunk_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               empty_res;
      logic               last;
      logic [COUNT_W-1:0] items_left;
   } rsp_type;

   typedef struct packed {
      logic                busy;
      logic [IBYTES_W-1:0] bytes;
      logic [SLOTS_W-1:0]  slots;
   } geom_type;

endpackage

/* sv/oirb_ram.sv */
// Single-port synchronous byte memory with a registered read port.
// Generic; no package dependency.
module oirb_ram #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/oirb_geom.sv */
// Configuration registers and effective geometry of the ring buffer.
// Depends on oirb_pkg; the slot limit comes from a bit-serial division of the memory size.
module oirb_geom (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [oirb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [oirb_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output oirb_pkg::geom_type                   geom
);

   logic [oirb_pkg::IBYTES_W-1:0]   item_bytes_ff, item_bytes_in;
   logic [oirb_pkg::SLOTS_W-1:0]    item_slots_ff, item_slots_in;
   logic                            busy_ff, busy_in;
   logic [oirb_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic [oirb_pkg::IBYTES_W-1:0]   rem_ff, rem_in;
   logic [oirb_pkg::DIV_W-1:0]      quot_ff, quot_in;
   logic [oirb_pkg::SLOTS_W-1:0]    slots_ff, slots_in;

   logic [oirb_pkg::IBYTES_W-1:0]   eff_bytes;
   logic [oirb_pkg::SLOTS_W-1:0]    clamp_slots;
   logic [oirb_pkg::DIV_STEP_W-1:0] bit_idx;
   logic [oirb_pkg::IBYTES_W:0]     shifted;
   logic                            fits;
   logic                            wr_bytes, wr_slots;

   assign wr_bytes = csr_valid && (csr_index == oirb_pkg::CSR_ITEM_BYTES);
   assign wr_slots = csr_valid && (csr_index == oirb_pkg::CSR_ITEM_SLOTS);

   always_comb begin
      if (item_bytes_ff == '0) begin
         eff_bytes = oirb_pkg::IBYTES_W'(1);
      end else if (item_bytes_ff > oirb_pkg::IBYTES_W'(oirb_pkg::MAX_ITEM_BYTES)) begin
         eff_bytes = oirb_pkg::IBYTES_W'(oirb_pkg::MAX_ITEM_BYTES);
      end else begin
         eff_bytes = item_bytes_ff;
      end
      if (item_slots_ff == '0) begin
         clamp_slots = oirb_pkg::SLOTS_W'(1);
      end else if (item_slots_ff > oirb_pkg::SLOTS_W'(oirb_pkg::SLOT_LIMIT)) begin
         clamp_slots = oirb_pkg::SLOTS_W'(oirb_pkg::SLOT_LIMIT);
      end else begin
         clamp_slots = item_slots_ff;
      end
   end

   always_comb begin
      bit_idx = oirb_pkg::DIV_STEP_W'(oirb_pkg::DIV_W - 1) - step_ff;
      shifted = {rem_ff, oirb_pkg::MEM_BYTES_VEC[bit_idx]};
      fits    = shifted >= {1'b0, eff_bytes};

      item_bytes_in = item_bytes_ff;
      item_slots_in = item_slots_ff;
      busy_in       = busy_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      slots_in      = slots_ff;

      if (wr_bytes || wr_slots) begin
         if (wr_bytes) begin
            item_bytes_in = csr_wdata[oirb_pkg::IBYTES_W-1:0];
         end
         if (wr_slots) begin
            item_slots_in = csr_wdata[oirb_pkg::SLOTS_W-1:0];
         end
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? oirb_pkg::IBYTES_W'(shifted - {1'b0, eff_bytes})
                        : shifted[oirb_pkg::IBYTES_W-1:0];
         quot_in = {quot_ff[oirb_pkg::DIV_W-2:0], fits};
         step_in = step_ff + oirb_pkg::DIV_STEP_W'(1);
         if (step_ff == oirb_pkg::DIV_STEP_W'(oirb_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            if (oirb_pkg::CMP_W'(quot_in) < oirb_pkg::CMP_W'(clamp_slots)) begin
               slots_in = oirb_pkg::SLOTS_W'(quot_in);
            end else begin
               slots_in = clamp_slots;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_bytes_ff <= oirb_pkg::ITEM_BYTES_RESET;
         item_slots_ff <= oirb_pkg::ITEM_SLOTS_RESET;
         busy_ff       <= 1'b1;
         step_ff       <= '0;
         rem_ff        <= '0;
         quot_ff       <= '0;
         slots_ff      <= '0;
      end else begin
         item_bytes_ff <= item_bytes_in;
         item_slots_ff <= item_slots_in;
         busy_ff       <= busy_in;
         step_ff       <= step_in;
         rem_ff        <= rem_in;
         quot_ff       <= quot_in;
         slots_ff      <= slots_in;
      end
   end

   assign geom.busy  = busy_ff;
   assign geom.bytes = eff_bytes;
   assign geom.slots = slots_ff;

endmodule

/* sv/overwriting_item_ring_buffer.sv */
// Overwriting item ring buffer. A push transfer writes one byte; a read transfer of a stored
// item returns item_bytes bytes, one byte per cycle while results are taken, out of the single
// port of the byte memory, and an empty read returns one empty result. Pushes and reads share
// that port, so a new request is taken once the previous burst has been issued. After reset and
// after every configuration write the block works out the slot limit by a bit-serial division
// and accepts no request meanwhile; the store needs no clearing.
// Depends on oirb_pkg, oirb_geom, oirb_ram and overwriting_item_ring_buffer_defines.svh.
`include "overwriting_item_ring_buffer_defines.svh"

module overwriting_item_ring_buffer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  oirb_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output oirb_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [oirb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [oirb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   oirb_pkg::geom_type  geom;
   oirb_pkg::state_type state_ff, state_in;

   logic [oirb_pkg::SLOT_IDX_W-1:0] read_slot_ff, read_slot_in;
   logic [oirb_pkg::ADDR_W-1:0]     read_byte_addr_ff, read_byte_addr_in;
   logic [oirb_pkg::SLOT_IDX_W-1:0] write_slot_ff, write_slot_in;
   logic [oirb_pkg::ADDR_W-1:0]     write_byte_addr_ff, write_byte_addr_in;
   logic [oirb_pkg::BIS_W-1:0]      byte_in_slot_ff, byte_in_slot_in;
   logic [oirb_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [oirb_pkg::ADDR_W-1:0]     burst_addr_ff, burst_addr_in;
   logic [oirb_pkg::IBYTES_W-1:0]   burst_left_ff, burst_left_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_empty_ff, rsp_empty_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [oirb_pkg::COUNT_W-1:0]    rsp_items_left_ff, rsp_items_left_in;

   logic                            req_fire, out_free, csr_clear;
   logic                            is_read, is_push, is_clear, burst_issue;
   logic                            read_wrap, write_wrap, drop, slot_done;
   logic [oirb_pkg::SLOT_IDX_W-1:0] read_slot_adv;
   logic [oirb_pkg::ADDR_W-1:0]     read_addr_adv;
   logic [oirb_pkg::COUNT_W-1:0]    count_kept;
   logic                            ram_wr_en, ram_rd_en;
   logic [oirb_pkg::ADDR_W-1:0]     ram_addr;
   logic [oirb_pkg::BYTE_W-1:0]     ram_rd_data;

   oirb_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   oirb_ram #(
      .DEPTH (oirb_pkg::MEM_BYTES),
      .WIDTH (oirb_pkg::BYTE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (req_data.data_byte),
      .rd_data (ram_rd_data)
   );

   assign csr_ready = 1'b1;
   assign csr_clear = csr_valid && ((csr_index == oirb_pkg::CSR_ITEM_BYTES) ||
                                    (csr_index == oirb_pkg::CSR_ITEM_SLOTS));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == oirb_pkg::ST_IDLE) && !geom.busy &&
                      ((req_data.op != oirb_pkg::OP_READ) || out_free);
   assign req_fire  = req_valid && req_ready;
   assign is_read   = req_fire && (req_data.op == oirb_pkg::OP_READ);
   assign is_push   = req_fire && (req_data.op == oirb_pkg::OP_PUSH);
   assign is_clear  = req_fire && (req_data.op == oirb_pkg::OP_CLEAR);
   assign burst_issue = (state_ff == oirb_pkg::ST_BURST) && out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         oirb_pkg::ST_IDLE: begin
            if (is_read && (count_ff != '0) && (geom.bytes != oirb_pkg::IBYTES_W'(1))) begin
               state_in = oirb_pkg::ST_BURST;
            end
         end
         oirb_pkg::ST_BURST: begin
            if (burst_issue && (burst_left_ff == oirb_pkg::IBYTES_W'(1))) begin
               state_in = oirb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = oirb_pkg::ST_IDLE;
         end
      endcase
   end

   // Pointers, memory access and the result register.
   always_comb begin
      read_wrap     = ({1'b0, read_slot_ff} + oirb_pkg::SLOTS_W'(1)) >= geom.slots;
      read_slot_adv = read_wrap ? '0 : read_slot_ff + oirb_pkg::SLOT_IDX_W'(1);
      read_addr_adv = read_wrap ? '0 : read_byte_addr_ff + oirb_pkg::ADDR_W'(geom.bytes);
      write_wrap    = ({1'b0, write_slot_ff} + oirb_pkg::SLOTS_W'(1)) >= geom.slots;
      drop          = (byte_in_slot_ff == '0) && (count_ff >= geom.slots);
      count_kept    = drop ? geom.slots - oirb_pkg::COUNT_W'(1) : count_ff;
      slot_done     = (oirb_pkg::IBYTES_W'(byte_in_slot_ff) + oirb_pkg::IBYTES_W'(1))
                      == geom.bytes;

      read_slot_in       = read_slot_ff;
      read_byte_addr_in  = read_byte_addr_ff;
      write_slot_in      = write_slot_ff;
      write_byte_addr_in = write_byte_addr_ff;
      byte_in_slot_in    = byte_in_slot_ff;
      count_in           = count_ff;
      burst_addr_in      = burst_addr_ff;
      burst_left_in      = burst_left_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_empty_in       = rsp_empty_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_items_left_in  = rsp_items_left_ff;
      ram_wr_en          = 1'b0;
      ram_rd_en          = 1'b0;
      ram_addr           = read_byte_addr_ff;

      if (is_push) begin
         ram_wr_en = 1'b1;
         ram_addr  = write_byte_addr_ff;
         if (drop) begin
            read_slot_in      = read_slot_adv;
            read_byte_addr_in = read_addr_adv;
         end
         count_in = count_kept;
         if (slot_done) begin
            byte_in_slot_in    = '0;
            write_slot_in      = write_wrap ? '0 : write_slot_ff + oirb_pkg::SLOT_IDX_W'(1);
            write_byte_addr_in = write_wrap ? '0
                                            : write_byte_addr_ff + oirb_pkg::ADDR_W'(1);
            if (count_kept < geom.slots) begin
               count_in = count_kept + oirb_pkg::COUNT_W'(1);
            end
         end else begin
            byte_in_slot_in    = byte_in_slot_ff + oirb_pkg::BIS_W'(1);
            write_byte_addr_in = write_byte_addr_ff + oirb_pkg::ADDR_W'(1);
         end
      end else if (is_read) begin
         rsp_valid_in = 1'b1;
         if (count_ff == '0) begin
            rsp_empty_in      = 1'b1;
            rsp_last_in       = 1'b1;
            rsp_items_left_in = '0;
         end else begin
            ram_rd_en         = 1'b1;
            rsp_empty_in      = 1'b0;
            rsp_last_in       = geom.bytes == oirb_pkg::IBYTES_W'(1);
            rsp_items_left_in = count_ff - oirb_pkg::COUNT_W'(1);
            count_in          = count_ff - oirb_pkg::COUNT_W'(1);
            burst_addr_in     = read_byte_addr_ff + oirb_pkg::ADDR_W'(1);
            burst_left_in     = geom.bytes - oirb_pkg::IBYTES_W'(1);
            read_slot_in      = read_slot_adv;
            read_byte_addr_in = read_addr_adv;
         end
      end else if (burst_issue) begin
         ram_rd_en     = 1'b1;
         ram_addr      = burst_addr_ff;
         rsp_valid_in  = 1'b1;
         rsp_empty_in  = 1'b0;
         rsp_last_in   = burst_left_ff == oirb_pkg::IBYTES_W'(1);
         burst_addr_in = burst_addr_ff + oirb_pkg::ADDR_W'(1);
         burst_left_in = burst_left_ff - oirb_pkg::IBYTES_W'(1);
      end

      if (is_clear || csr_clear) begin
         read_slot_in       = '0;
         read_byte_addr_in  = '0;
         write_slot_in      = '0;
         write_byte_addr_in = '0;
         byte_in_slot_in    = '0;
         count_in           = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= oirb_pkg::ST_IDLE;
         read_slot_ff       <= '0;
         read_byte_addr_ff  <= '0;
         write_slot_ff      <= '0;
         write_byte_addr_ff <= '0;
         byte_in_slot_ff    <= '0;
         count_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         read_slot_ff       <= read_slot_in;
         read_byte_addr_ff  <= read_byte_addr_in;
         write_slot_ff      <= write_slot_in;
         write_byte_addr_ff <= write_byte_addr_in;
         byte_in_slot_ff    <= byte_in_slot_in;
         count_ff           <= count_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_addr_ff     <= burst_addr_in;
      burst_left_ff     <= burst_left_in;
      rsp_empty_ff      <= rsp_empty_in;
      rsp_last_ff       <= rsp_last_in;
      rsp_items_left_ff <= rsp_items_left_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.out_byte   = rsp_empty_ff ? '0 : ram_rd_data;
   assign rsp_data.empty_res  = rsp_empty_ff;
   assign rsp_data.last       = rsp_last_ff;
   assign rsp_data.items_left = rsp_items_left_ff;

   `OIRB_ASSERT_NOW(a_count_cap, !geom.busy, count_ff <= geom.slots,
                    "Item count exceeds the slot limit.")
   `OIRB_ASSERT_NOW(a_read_into_free, ram_rd_en, !rsp_valid_ff || rsp_ready,
                    "Memory read issued while a result transfer is still pending.")
   `OIRB_ASSERT_NOW(a_no_accept_in_burst, state_ff == oirb_pkg::ST_BURST, !req_ready,
                    "Request accepted during a read burst.")
   `OIRB_ASSERT_NEXT(a_csr_clears, csr_clear && !req_fire,
                     count_ff == '0 && byte_in_slot_ff == '0 && geom.busy,
                     "Configuration write did not clear the buffer.")

endmodule
